// File: src/line_sensor_track_center_assert.svh
// Assertion macros for the track centre finder
`ifndef LINE_SENSOR_TRACK_CENTER_ASSERT_SVH
`define LINE_SENSOR_TRACK_CENTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define LSTC_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("lstc assertion failed");
`define LSTC_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("lstc assertion failed");
`else
`define LSTC_ASSERT_IMP(name, clk_s, rst_s, ante, cons)
`define LSTC_ASSERT_NXT(name, clk_s, rst_s, ante, cons)
`endif

`endif

// File: src/lstc_pkg.sv
`default_nettype none
package lstc_pkg;

  localparam int unsigned PIXELS_DEF = 128;
  localparam int unsigned CENTER_DEF = 64;
  localparam int unsigned LINE_W     = 128;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned CFG_W      = 8;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_PIXEL_COUNT = 2'd0;
  localparam cfg_idx_t REG_OFFSET      = 2'd1;
  localparam cfg_idx_t REG_HALF_WIDTH  = 2'd2;

  localparam logic [7:0] COUNT_RST  = 8'd128;
  localparam logic [5:0] OFFSET_RST = 6'd0;
  localparam logic [6:0] HALF_RST   = 7'd32;

  localparam logic signed [7:0] EDGE_NONE = -8'sd1;

  typedef struct packed {
    logic [63:0] pixels_low;
    logic [63:0] pixels_high;
    logic        recenter;
  } lstc_in_t;

  typedef struct packed {
    logic signed [8:0] mid_position;
    logic signed [7:0] left_edge;
    logic signed [7:0] right_edge;
    logic              all_black;
    logic              all_white;
  } lstc_out_t;

  typedef struct packed {
    logic             all_black;
    logic             all_white;
    logic             left_found;
    logic [IDX_W-1:0] left_idx;
    logic             right_found;
    logic [IDX_W-1:0] right_idx;
  } lstc_scan_t;

endpackage
`default_nettype wire

// File: src/lstc_fill_scan.sv
`default_nettype none
module lstc_fill_scan #(
  parameter int unsigned PIXELS = 128
) (
  input  logic [lstc_pkg::LINE_W-1:0] line,
  input  logic [7:0]                  cnt,
  input  logic [5:0]                  off,
  input  logic signed [9:0]           prev,
  output lstc_pkg::lstc_scan_t        scan
);
  import lstc_pkg::*;

  logic [PIXELS-1:0] black;
  logic [PIXELS-1:0] in_fill;
  logic [PIXELS-1:0] left_hit;
  logic [PIXELS-1:0] right_hit;
  logic signed [10:0] off_s;
  logic signed [10:0] cnt_s;
  logic signed [10:0] prev_s;
  logic signed [10:0] fill_end;
  logic signed [10:0] top_s;
  logic signed [10:0] start_s;
  logic               beyond;

  always_comb begin
    off_s    = $signed({5'd0, off});
    cnt_s    = $signed({3'd0, cnt});
    prev_s   = 11'(prev);
    fill_end = cnt_s - off_s;
    top_s    = cnt_s + off_s - 11'sd1;
    if (prev_s < off_s) begin
      start_s = off_s;
    end else if (prev_s > top_s) begin
      start_s = top_s;
    end else begin
      start_s = prev_s;
    end
    beyond = fill_end > $signed(11'(PIXELS));
  end

  always_comb begin
    for (int i = 0; i < PIXELS; i++) begin
      black[i]     = ~line[i];
      in_fill[i]   = ($signed(11'(i)) >= off_s) && ($signed(11'(i)) < fill_end);
      left_hit[i]  = black[i] && ($signed(11'(i)) >= off_s) && ($signed(11'(i)) <= start_s);
      right_hit[i] = black[i] && ($signed(11'(i)) >= start_s) && ($signed(11'(i)) <= top_s);
    end
  end

  // nearest black left of start: highest hit; right of start: lowest hit
  always_comb begin
    scan.all_white   = ~|(black & in_fill);
    scan.all_black   = ~|(~black & in_fill) && !beyond;
    scan.left_found  = 1'b0;
    scan.left_idx    = '0;
    scan.right_found = 1'b0;
    scan.right_idx   = '0;
    for (int i = 0; i < PIXELS; i++) begin
      if (left_hit[i]) begin
        scan.left_found = 1'b1;
        scan.left_idx   = IDX_W'(i);
      end
    end
    for (int i = PIXELS - 1; i >= 0; i--) begin
      if (right_hit[i]) begin
        scan.right_found = 1'b1;
        scan.right_idx   = IDX_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// File: src/lstc_mid_calc.sv
`default_nettype none
module lstc_mid_calc #(
  parameter int unsigned CENTER_POSITION = 64
) (
  input  lstc_pkg::lstc_scan_t scan,
  input  logic                 recenter,
  input  logic signed [9:0]    prev,
  input  logic [7:0]           cnt,
  input  logic [5:0]           off,
  input  logic [6:0]           htw,
  output lstc_pkg::lstc_out_t  result,
  output logic signed [9:0]    mid_nxt
);
  import lstc_pkg::*;

  logic signed [11:0] le_s;
  logic signed [11:0] re_s;
  logic signed [11:0] off_s;
  logic signed [11:0] cnt_s;
  logic signed [11:0] tw_s;
  logic signed [11:0] extra;
  logic signed [11:0] sum;
  logic signed [11:0] half;

  always_comb begin
    le_s  = $signed({5'd0, scan.left_idx});
    re_s  = $signed({5'd0, scan.right_idx});
    off_s = $signed({6'd0, off});
    cnt_s = $signed({4'd0, cnt});
    tw_s  = $signed({4'd0, htw, 1'b0});
    extra = '0;
    if (scan.left_found && scan.right_found) begin
      sum = le_s + re_s;
    end else if (!scan.left_found) begin
      extra = tw_s - (re_s - off_s);
      if (extra < 0) begin
        extra = '0;
      end
      sum = off_s - extra + re_s;
    end else begin
      extra = tw_s - (cnt_s - le_s);
      if (extra < 0) begin
        extra = '0;
      end
      sum = le_s + cnt_s + extra;
    end
    // halve, truncating toward zero
    half = $signed(sum + 12'(sum[11])) >>> 1;
  end

  always_comb begin
    if (recenter) begin
      mid_nxt             = 10'(CENTER_POSITION);
      result.mid_position = 9'(CENTER_POSITION);
      result.left_edge    = EDGE_NONE;
      result.right_edge   = EDGE_NONE;
      result.all_black    = 1'b0;
      result.all_white    = 1'b0;
    end else if (scan.all_black || scan.all_white) begin
      mid_nxt             = prev;
      result.mid_position = prev[8:0];
      result.left_edge    = EDGE_NONE;
      result.right_edge   = EDGE_NONE;
      result.all_black    = scan.all_black;
      result.all_white    = scan.all_white;
    end else begin
      mid_nxt             = half[9:0];
      result.mid_position = half[8:0];
      result.left_edge    = scan.left_found ? $signed({1'b0, scan.left_idx}) : EDGE_NONE;
      result.right_edge   = scan.right_found ? $signed({1'b0, scan.right_idx}) : EDGE_NONE;
      result.all_black    = 1'b0;
      result.all_white    = 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: src/line_sensor_track_center.sv
// Track centre finder for a binarised 128-pixel line.
// Registers: the accepted input beat is held in s1_data_r, its result beat in out_data_r.
// Throughput: one line per cycle while out_stall does not hold the pipeline; the fill test,
// edge search and midpoint update are combinational, in a loop through the stored midpoint.
// Reset (rst_n low, synchronous): pipeline emptied, registers to defaults, midpoint to 64.
`default_nettype none
module line_sensor_track_center #(
  parameter int unsigned PIXELS          = lstc_pkg::PIXELS_DEF,
  parameter int unsigned CENTER_POSITION = lstc_pkg::CENTER_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lstc_pkg::lstc_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lstc_pkg::lstc_out_t         out_data,
  input  logic                        cfg_we,
  input  lstc_pkg::cfg_idx_t          cfg_index,
  input  logic [lstc_pkg::CFG_W-1:0]  cfg_wdata
);
  import lstc_pkg::*;

  logic [7:0]        cnt_r;
  logic [5:0]        off_r;
  logic [6:0]        htw_r;
  logic signed [9:0] last_mid_r;
  logic signed [9:0] mid_nxt;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  lstc_in_t          s1_data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  lstc_out_t         out_data_r;
  lstc_out_t         result;
  lstc_scan_t        scan;
  logic              out_free;
  logic              adv;
  logic              in_acc;

  assign out_free      = !out_valid_r || !out_stall;
  assign adv           = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_acc        = in_valid && !in_stall;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  lstc_fill_scan #(
    .PIXELS(PIXELS)
  ) u_scan (
    .line ({s1_data_r.pixels_high, s1_data_r.pixels_low}),
    .cnt  (cnt_r),
    .off  (off_r),
    .prev (last_mid_r),
    .scan (scan)
  );

  lstc_mid_calc #(
    .CENTER_POSITION(CENTER_POSITION)
  ) u_mid (
    .scan     (scan),
    .recenter (s1_data_r.recenter),
    .prev     (last_mid_r),
    .cnt      (cnt_r),
    .off      (off_r),
    .htw      (htw_r),
    .result   (result),
    .mid_nxt  (mid_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_mid_r  <= 10'(CENTER_POSITION);
      cnt_r       <= COUNT_RST;
      off_r       <= OFFSET_RST;
      htw_r       <= HALF_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        last_mid_r <= mid_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PIXEL_COUNT: cnt_r <= cfg_wdata[7:0];
          REG_OFFSET:      off_r <= cfg_wdata[5:0];
          REG_HALF_WIDTH:  htw_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= result;
    end
  end

`include "line_sensor_track_center_assert.svh"

  // a filled line or a recentre beat carries no edges
  `LSTC_ASSERT_IMP(a_fill_no_edge, clk, rst_n, out_valid_r && (out_data_r.all_black || out_data_r.all_white), out_data_r.left_edge == EDGE_NONE && out_data_r.right_edge == EDGE_NONE)
  `LSTC_ASSERT_NXT(a_recenter, clk, rst_n, adv && s1_data_r.recenter, last_mid_r == 10'(CENTER_POSITION) && out_data_r.mid_position == 9'(CENTER_POSITION))
  `LSTC_ASSERT_NXT(a_held_beat, clk, rst_n, in_stall, s1_valid_r)
  `LSTC_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, out_valid_r && out_stall)

endmodule
`default_nettype wire

// File: tb/lstc_track_checker.sv
`timescale 1ns / 100ps
module lstc_track_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  lstc_pkg::lstc_in_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  lstc_pkg::lstc_out_t        out_data,
  input  logic                       cfg_we,
  input  lstc_pkg::cfg_idx_t         cfg_index,
  input  logic [lstc_pkg::CFG_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         pending
);
  import lstc_pkg::*;

  logic [7:0]        cur_count;
  logic [5:0]        cur_offset;
  logic [6:0]        cur_half;
  logic signed [9:0] track_mid;
  lstc_out_t         expected_tracks[$];
  int                mismatch_cnt = 0;

  assign mismatches = mismatch_cnt;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t track %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic logic pixel_dark(input logic [127:0] line, input int idx);
    if (idx < 0 || idx >= int'(PIXELS_DEF))
      return 1'b0;
    return !line[idx];
  endfunction

  function automatic lstc_out_t predict_track(input lstc_in_t beat,
                                              input logic signed [9:0] prev,
                                              output logic signed [9:0] next_mid);
    logic [127:0] line;
    lstc_out_t    r;
    logic         blk;
    logic         wht;
    int           off;
    int           cnt;
    int           top;
    int           start;
    int           le;
    int           re;
    int           mid;
    int           extra;
    int           i;
    line = {beat.pixels_high, beat.pixels_low};
    off = int'(cur_offset);
    cnt = int'(cur_count);
    r.left_edge = EDGE_NONE;
    r.right_edge = EDGE_NONE;
    r.all_black = 1'b0;
    r.all_white = 1'b0;
    if (beat.recenter) begin
      next_mid = 10'(CENTER_DEF);
      r.mid_position = 9'(CENTER_DEF);
      return r;
    end
    blk = 1'b1;
    wht = 1'b1;
    for (i = off; i < cnt - off; i++) begin
      if (pixel_dark(line, i))
        wht = 1'b0;
      else
        blk = 1'b0;
    end
    if (blk || wht) begin
      next_mid = prev;
      r.mid_position = prev[8:0];
      r.all_black = blk;
      r.all_white = wht;
      return r;
    end
    top = cnt + off - 1;
    start = prev;
    if (start < off)
      start = off;
    else if (start > top)
      start = top;
    le = -1;
    re = -1;
    for (i = start; i >= off; i--) begin
      if (pixel_dark(line, i)) begin
        le = i;
        break;
      end
    end
    for (i = start; i <= top; i++) begin
      if (pixel_dark(line, i)) begin
        re = i;
        break;
      end
    end
    if (le != -1 && re != -1) begin
      mid = (le + re) / 2;
    end else if (le == -1) begin
      extra = 2 * int'(cur_half) - (re - off);
      if (extra < 0)
        extra = 0;
      mid = ((off - extra) + re) / 2;
    end else begin
      extra = 2 * int'(cur_half) - (cnt - le);
      if (extra < 0)
        extra = 0;
      mid = (le + (cnt + extra)) / 2;
    end
    next_mid = mid[9:0];
    r.mid_position = mid[8:0];
    r.left_edge = le[7:0];
    r.right_edge = re[7:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lstc_out_t         want;
    logic signed [9:0] nxt;
    if (!rst_n) begin
      cur_count = COUNT_RST;
      cur_offset = OFFSET_RST;
      cur_half = HALF_RST;
      track_mid = 10'(CENTER_DEF);
      expected_tracks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PIXEL_COUNT: cur_count = cfg_wdata;
          REG_OFFSET:      cur_offset = cfg_wdata[5:0];
          REG_HALF_WIDTH:  cur_half = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = predict_track(in_data, track_mid, nxt);
        track_mid = nxt;
        expected_tracks.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_tracks.size() == 0) begin
          report_mismatch("beat with nothing expected", out_data.mid_position, 0);
        end else begin
          want = expected_tracks.pop_front();
          if (out_data.mid_position !== want.mid_position)
            report_mismatch("mid_position", out_data.mid_position, want.mid_position);
          if (out_data.left_edge !== want.left_edge)
            report_mismatch("left_edge", out_data.left_edge, want.left_edge);
          if (out_data.right_edge !== want.right_edge)
            report_mismatch("right_edge", out_data.right_edge, want.right_edge);
          if (out_data.all_black !== want.all_black)
            report_mismatch("all_black", out_data.all_black, want.all_black);
          if (out_data.all_white !== want.all_white)
            report_mismatch("all_white", out_data.all_white, want.all_white);
        end
      end
    end
    pending <= expected_tracks.size();
  end
endmodule

// File: tb/tb_line_sensor_track_center.sv
`timescale 1ns / 100ps
module tb_line_sensor_track_center;
  import lstc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  lstc_in_t         in_data = '0;
  logic             out_stall = 1'b0;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_index = REG_PIXEL_COUNT;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_stall;
  logic             out_valid;
  lstc_out_t        out_data;
  int               mismatches;
  int               pending;
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  int               cycle_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_sensor_track_center dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lstc_track_checker track_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  function automatic lstc_in_t make_beat(input logic [127:0] line, input logic rc);
    lstc_in_t b;
    b.pixels_low = line[63:0];
    b.pixels_high = line[127:64];
    b.recenter = rc;
    return b;
  endfunction

  // pixels in [lo, hi] take v, the rest !v
  function automatic logic [127:0] fill_band(input int lo, input int hi, input logic v);
    logic [127:0] line;
    for (int i = 0; i < 128; i++)
      line[i] = (i >= lo && i <= hi) ? v : !v;
    return line;
  endfunction

  function automatic lstc_in_t random_line();
    logic [127:0] line;
    int           kind;
    int           c;
    int           w;
    kind = $urandom_range(0, 99);
    c = $urandom_range(0, 127);
    w = $urandom_range(1, 100);
    if (kind < 55)
      line = fill_band(c - w / 2, c + w / 2, 1'b1);
    else if (kind < 70)
      line = fill_band(c, c + $urandom_range(0, 8), 1'b0);
    else if (kind < 80)
      line = ($urandom_range(0, 1) == 1) ? fill_band(0, c, 1'b1) : fill_band(c, 127, 1'b1);
    else if (kind < 88)
      line = {$urandom, $urandom, $urandom, $urandom};
    else if (kind < 92)
      line = ($urandom_range(0, 1) == 1) ? '1 : '0;
    else if (kind < 97)
      return make_beat({$urandom, $urandom, $urandom, $urandom}, 1'b1);
    else
      line = fill_band(c, c, 1'b0);
    if (kind < 80 && $urandom_range(0, 1) == 1) begin
      for (int i = 0; i < 128; i++)
        if ($urandom_range(0, 49) == 0)
          line[i] = !line[i];
    end
    return make_beat(line, 1'b0);
  endfunction

  task automatic push_line(input lstc_in_t beat);
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input int cnt, input int off, input int half);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_PIXEL_COUNT;
    cfg_wdata <= 8'(cnt);
    @(posedge clk);
    cfg_index <= REG_OFFSET;
    cfg_wdata <= 8'(off);
    @(posedge clk);
    cfg_index <= REG_HALF_WIDTH;
    cfg_wdata <= 8'(half);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats at reset settings
    push_line(make_beat('1, 1'b0));
    push_line(make_beat('0, 1'b0));
    push_line(make_beat(fill_band(40, 90, 1'b1), 1'b0));
    push_line(make_beat(fill_band(0, 80, 1'b1), 1'b0));
    push_line(make_beat(fill_band(30, 127, 1'b1), 1'b0));
    push_line(make_beat('0, 1'b1));
    push_line(make_beat(fill_band(0, 0, 1'b0), 1'b0));
    push_line(make_beat(fill_band(127, 127, 1'b0), 1'b0));
    push_line(make_beat({32{4'h5}}, 1'b0));
    push_line(make_beat({32{4'hA}}, 1'b0));

    // virtual edges pushing the midpoint below zero and past the line
    set_regs(128, 0, 127);
    push_line(make_beat('1, 1'b1));
    push_line(make_beat(fill_band(100, 127, 1'b0), 1'b0));
    push_line(make_beat(fill_band(0, 20, 1'b0), 1'b0));
    push_line(make_beat('0, 1'b1));
    push_line(make_beat(fill_band(0, 20, 1'b0), 1'b0));
    push_line(make_beat(fill_band(0, 10, 1'b0), 1'b0));

    // empty fill range
    set_regs(60, 30, 0);
    push_line(make_beat(fill_band(40, 90, 1'b1), 1'b0));
    push_line(make_beat({$urandom, $urandom, $urandom, $urandom}, 1'b0));

    set_regs(1, 0, 0);
    push_line(make_beat(fill_band(0, 0, 1'b0), 1'b0));
    push_line(make_beat(fill_band(0, 0, 1'b1), 1'b0));

    // scan window running past the last pixel
    set_regs(120, 40, 127);
    push_line(make_beat(fill_band(50, 70, 1'b1), 1'b0));
    push_line(make_beat(fill_band(50, 127, 1'b1), 1'b0));
    push_line(make_beat(fill_band(60, 127, 1'b1), 1'b0));

    for (int seg = 0; seg < 9; seg++) begin
      if (seg < 3) begin
        tx_idle_pct = 10;
        rx_idle_pct = 61;
      end else if (seg < 6) begin
        tx_idle_pct = 61;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (seg)
        0: set_regs(128, 0, 32);
        1: set_regs(96, 16, 20);
        2: set_regs(128, 63, 64);
        3: set_regs(120, 40, 127);
        4: set_regs(128, 10, 0);
        5: set_regs(64, 0, 48);
        default: set_regs($urandom_range(1, 128), $urandom_range(0, 24),
                          $urandom_range(0, 127));
      endcase
      repeat (100) push_line(random_line());
    end

    settle();
    repeat (6) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/lstc_pkg.sv
src/lstc_fill_scan.sv
src/lstc_mid_calc.sv
src/line_sensor_track_center.sv
tb/lstc_track_checker.sv
tb/tb_line_sensor_track_center.sv
